### sv/etd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_pkg: shared types, constants and control store
// Holds the data width default, the control word layout and the microprogram
// that sequences the trial-division totient datapath.
// ----------------------------------------------------------------------------
package etd_pkg;

	localparam int ETD_DATA_WIDTH = 31;
	localparam int ETD_PC_W       = 5;

	typedef logic [ETD_PC_W-1:0] etd_pc_t;

	// datapath actions, one per control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,    // take an input beat: answer = rest = n, d = 2
		OP_DIV_RD,  // start divider on rest / d
		OP_DIV_AD,  // start divider on answer / d
		OP_DIV_AR,  // start divider on answer / rest
		OP_REST_Q,  // rest = quotient
		OP_SUB,     // answer = answer - quotient
		OP_INC_D    // d = d + 1
	} etd_op_t;

	localparam etd_op_t OP_EMIT = OP_NOP;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_ZERO,
		C_BUSY,
		C_Q_LT_D,
		C_R_NZ,
		C_REST_LE1,
		C_OUT_FULL
	} etd_cond_t;

	typedef struct packed {
		etd_op_t   op;
		logic      emit;
		etd_cond_t cond;
		etd_pc_t   target;
	} etd_uword_t;

	// status flags from datapath to sequencer
	typedef struct packed {
		logic in_acc;
		logic ans_zero;
		logic busy;
		logic q_lt_d;
		logic r_nz;
		logic rest_le1;
		logic out_full;
	} etd_status_t;

	// control from sequencer to datapath
	typedef struct packed {
		etd_op_t op;
		logic    emit;
	} etd_ctrl_t;

	// program labels
	localparam etd_pc_t PC_WAIT    = 5'd0;
	localparam etd_pc_t PC_CHKZ    = 5'd1;
	localparam etd_pc_t PC_LOOP    = 5'd2;
	localparam etd_pc_t PC_WAIT_RD = 5'd3;
	localparam etd_pc_t PC_TEST_SQ = 5'd4;
	localparam etd_pc_t PC_TEST_R  = 5'd5;
	localparam etd_pc_t PC_FIRST_Q = 5'd6;
	localparam etd_pc_t PC_DIV_AD  = 5'd7;
	localparam etd_pc_t PC_WAIT_AD = 5'd8;
	localparam etd_pc_t PC_SUB_D   = 5'd9;
	localparam etd_pc_t PC_STRIP   = 5'd10;
	localparam etd_pc_t PC_WAIT_ST = 5'd11;
	localparam etd_pc_t PC_TEST_ST = 5'd12;
	localparam etd_pc_t PC_STRIP_Q = 5'd13;
	localparam etd_pc_t PC_NEXT    = 5'd14;
	localparam etd_pc_t PC_TAIL    = 5'd15;
	localparam etd_pc_t PC_DIV_AR  = 5'd16;
	localparam etd_pc_t PC_WAIT_AR = 5'd17;
	localparam etd_pc_t PC_SUB_R   = 5'd18;
	localparam etd_pc_t PC_OUT     = 5'd19;
	localparam etd_pc_t PC_DONE    = 5'd20;

	// microprogram: when the condition holds jump to target, else fall through
	function automatic etd_uword_t etd_rom(input etd_pc_t pc);
		etd_uword_t w;
		w = '{op: OP_NOP, emit: 1'b0, cond: C_ALWAYS, target: PC_WAIT};
		case (pc)
			PC_WAIT:    w = '{OP_LOAD,   1'b0, C_NO_IN,    PC_WAIT};
			PC_CHKZ:    w = '{OP_NOP,    1'b0, C_ZERO,     PC_OUT};
			PC_LOOP:    w = '{OP_DIV_RD, 1'b0, C_NEVER,    PC_WAIT};
			PC_WAIT_RD: w = '{OP_NOP,    1'b0, C_BUSY,     PC_WAIT_RD};
			PC_TEST_SQ: w = '{OP_NOP,    1'b0, C_Q_LT_D,   PC_TAIL};
			PC_TEST_R:  w = '{OP_NOP,    1'b0, C_R_NZ,     PC_NEXT};
			PC_FIRST_Q: w = '{OP_REST_Q, 1'b0, C_NEVER,    PC_WAIT};
			PC_DIV_AD:  w = '{OP_DIV_AD, 1'b0, C_NEVER,    PC_WAIT};
			PC_WAIT_AD: w = '{OP_NOP,    1'b0, C_BUSY,     PC_WAIT_AD};
			PC_SUB_D:   w = '{OP_SUB,    1'b0, C_NEVER,    PC_WAIT};
			PC_STRIP:   w = '{OP_DIV_RD, 1'b0, C_NEVER,    PC_WAIT};
			PC_WAIT_ST: w = '{OP_NOP,    1'b0, C_BUSY,     PC_WAIT_ST};
			PC_TEST_ST: w = '{OP_NOP,    1'b0, C_R_NZ,     PC_NEXT};
			PC_STRIP_Q: w = '{OP_REST_Q, 1'b0, C_ALWAYS,   PC_STRIP};
			PC_NEXT:    w = '{OP_INC_D,  1'b0, C_ALWAYS,   PC_LOOP};
			PC_TAIL:    w = '{OP_NOP,    1'b0, C_REST_LE1, PC_OUT};
			PC_DIV_AR:  w = '{OP_DIV_AR, 1'b0, C_NEVER,    PC_WAIT};
			PC_WAIT_AR: w = '{OP_NOP,    1'b0, C_BUSY,     PC_WAIT_AR};
			PC_SUB_R:   w = '{OP_SUB,    1'b0, C_NEVER,    PC_WAIT};
			PC_OUT:     w = '{OP_EMIT,   1'b1, C_OUT_FULL, PC_OUT};
			PC_DONE:    w = '{OP_NOP,    1'b0, C_ALWAYS,   PC_WAIT};
			default:    w = '{OP_NOP,    1'b0, C_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

### sv/etd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_div: shared restoring divider
// Unsigned a / b, one quotient bit per cycle, DATA_WIDTH quotient bits per pass.
// Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module etd_div #(
	parameter int DATA_WIDTH = etd_pkg::ETD_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  busy,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem
);
	import etd_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	// count the quotient bits left in a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DATA_WIDTH);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	// advance one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_WIDTH]) begin
				rem_q <= diff[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### sv/etd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_seq: microcode sequencer
// Step counter over the control store, with conditional jumps on the
// datapath status flags.
// ----------------------------------------------------------------------------
module etd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  etd_pkg::etd_status_t status,
	output etd_pkg::etd_ctrl_t   ctrl
);
	import etd_pkg::*;

	etd_pc_t    pc_q;
	etd_uword_t uw;
	logic       take;

	assign uw = etd_rom(pc_q);

	// evaluate the jump condition
	always_comb begin
		case (uw.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = !status.in_acc;
			C_ZERO:     take = status.ans_zero;
			C_BUSY:     take = status.busy;
			C_Q_LT_D:   take = status.q_lt_d;
			C_R_NZ:     take = status.r_nz;
			C_REST_LE1: take = status.rest_le1;
			C_OUT_FULL: take = status.out_full;
			default:    take = 1'b1;
		endcase
	end

	// advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	assign ctrl = '{op: uw.op, emit: uw.emit};

endmodule

### sv/euler_totient_trial_division.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient_trial_division: Euler totient by trial division
// Microcoded sequencer driving a small datapath and one shared divider.
// ----------------------------------------------------------------------------
// One value is worked on at a time. Latency depends on the input. Each trial
// divisor costs one divider pass, during which the sequencer waits, plus the
// control steps that start the pass, test the quotient and remainder and step
// the divisor. Each prime factor found costs one more pass for the answer
// update, one pass per further power stripped and one last pass that fails to
// divide. The loop runs up to sqrt(n) divisors. A zero input goes straight
// from the zero check to the output, and an input of one takes a single
// divider pass. A large prime near 2^31 tries about 46341 divisors, and the
// shared divider sets its pace. A finished result waits in an output register,
// so the next value is taken while the previous result is still unread.
// ----------------------------------------------------------------------------
module euler_totient_trial_division #(
	parameter int DATA_WIDTH = etd_pkg::ETD_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] value_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] totient
);
	import etd_pkg::*;

	etd_status_t status;
	etd_ctrl_t   ctrl;

	logic [DATA_WIDTH-1:0] answer_q;
	logic [DATA_WIDTH-1:0] rest_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH-1:0] tot_q;
	logic                  out_valid_q;
	logic                  in_acc;
	logic                  div_start;
	logic                  div_busy;
	logic [DATA_WIDTH-1:0] div_a;
	logic [DATA_WIDTH-1:0] div_b;
	logic [DATA_WIDTH-1:0] div_quo;
	logic [DATA_WIDTH-1:0] div_rem;

	assign in_ready = (ctrl.op == OP_LOAD);
	assign in_acc   = in_valid && in_ready;

	// pick divider operands
	always_comb begin
		div_start = 1'b0;
		div_a     = rest_q;
		div_b     = d_q;
		case (ctrl.op)
			OP_DIV_RD: begin
				div_start = 1'b1;
			end
			OP_DIV_AD: begin
				div_start = 1'b1;
				div_a     = answer_q;
			end
			OP_DIV_AR: begin
				div_start = 1'b1;
				div_a     = answer_q;
				div_b     = rest_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	etd_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// status flags for the sequencer
	assign status = '{
		in_acc:   in_acc,
		ans_zero: (answer_q == '0),
		busy:     div_busy,
		q_lt_d:   (div_quo < d_q),
		r_nz:     (div_rem != '0),
		rest_le1: (rest_q <= DATA_WIDTH'(1)),
		out_full: out_valid_q
	};

	etd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_acc) begin
					answer_q <= value_in;
					rest_q   <= value_in;
					d_q      <= DATA_WIDTH'(2);
				end
			end
			OP_REST_Q: rest_q   <= div_quo;
			OP_SUB:    answer_q <= answer_q - div_quo;
			OP_INC_D:  d_q      <= d_q + 1'b1;
			default: begin
			end
		endcase
	end

	// output register: load on emit when empty, drop on beat taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && !out_valid_q) begin
			tot_q <= answer_q;
		end
	end

	assign out_valid = out_valid_q;
	assign totient   = tot_q;

endmodule

### sv/etd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etd_checker: port-level checks for the totient block
// Tracks beats in flight and the last input, and checks results against them.
// ----------------------------------------------------------------------------
module etd_checker #(
	parameter int DATA_WIDTH = etd_pkg::ETD_DATA_WIDTH
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [DATA_WIDTH-1:0] value_in,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] totient
);
	import etd_pkg::*;

	logic [1:0]            pend_q;
	logic [DATA_WIDTH-1:0] last_q;
	logic                  in_acc;
	logic                  out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q <= value_in;
		end
	end

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(totient))
		else $error("result changed while stalled");

	// no result without a beat in flight
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> pend_q != 2'd0)
		else $error("result with nothing pending");

	// at most one in work and one waiting
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q != 2'd2)
		else $error("input taken with two beats in flight");

	// totient never exceeds its input
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pend_q == 2'd1 |-> totient <= last_q)
		else $error("totient exceeds input");

	// totient is zero exactly for a zero input
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pend_q == 2'd1 |-> (totient == '0) == (last_q == '0))
		else $error("zero result mismatch");

endmodule

bind euler_totient_trial_division etd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_etd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.value_in  (value_in),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.totient   (totient)
);
